### rtl/cadr_pkg.sv
// ----------------------------------------------------------------------------
// cadr_pkg: shared types and constants for the catch-all DNS responder
// Parse phases, queue command format and reply byte tables.
// ----------------------------------------------------------------------------
package cadr_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned AnswerLen  = 16;
  localparam int unsigned HeaderLen  = 12;
  localparam int unsigned TailLen    = 4;

  localparam logic [31:0] AnswerIpv4Reset = 32'hC0A8_0401;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LABLEN,
    PH_LABEL,
    PH_TAIL,
    PH_DONE
  } phase_e;

  // what the back end does with one queue entry
  typedef enum logic [1:0] {
    CMD_ECHO,     // send data byte
    CMD_ANSWER,   // send data byte, then the A record
    CMD_DISCARD   // send one discard beat
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
  } cmd_t;

  // header rewrite: flags 81 80, ANCOUNT 1, NSCOUNT/ARCOUNT 0
  function automatic logic [7:0] header_byte(logic [3:0] pos, logic [7:0] b);
    logic [7:0] v;
    v = b;
    case (pos)
      4'd2:    v = 8'h81;
      4'd3:    v = 8'h80;
      4'd6:    v = 8'h00;
      4'd7:    v = 8'h01;
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15: v = 8'h00;
      default: v = b;
    endcase
    return v;
  endfunction

  // A record: C0 0C 00 01 00 01 00 00 00 00 00 04 ip3 ip2 ip1 ip0
  function automatic logic [7:0] answer_byte(logic [3:0] idx, logic [31:0] ip);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'hC0;
      4'd1:    v = 8'h0C;
      4'd3:    v = 8'h01;
      4'd5:    v = 8'h01;
      4'd11:   v = 8'h04;
      4'd12:   v = ip[31:24];
      4'd13:   v = ip[23:16];
      4'd14:   v = ip[15:8];
      4'd15:   v = ip[7:0];
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### rtl/cadr_if.sv
// ----------------------------------------------------------------------------
// cadr_if: stream and configuration channels of the DNS responder
// Valid/ready channels for query bytes, reply bytes and the address register.
// ----------------------------------------------------------------------------
interface cadr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_datagram;

  modport source (output valid, output rx_byte, output end_of_datagram, input ready);
  modport sink   (input valid, input rx_byte, input end_of_datagram, output ready);
endinterface

interface cadr_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       end_of_response;
  logic       discard;

  modport source (output valid, output tx_byte, output end_of_response,
                  output discard, input ready);
  modport sink   (input valid, input tx_byte, input end_of_response,
                  input discard, output ready);
endinterface

interface cadr_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] answer_ipv4;

  modport source (output valid, output answer_ipv4, input ready);
  modport sink   (input valid, input answer_ipv4, output ready);
endinterface

### rtl/cadr_front.sv
// ----------------------------------------------------------------------------
// cadr_front: query parser
// Walks header, labels and type/class of each query beat and pushes one
// command per beat that produces output.
// ----------------------------------------------------------------------------
module cadr_front #(
  parameter int unsigned MAX_DATAGRAM = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  cadr_rx_if.sink         rx,
  input  logic            q_full_i,
  output logic            q_push_o,
  output cadr_pkg::cmd_t  q_cmd_o
);

  localparam int unsigned PosW = $clog2(MAX_DATAGRAM + 1);

  cadr_pkg::phase_e phase_q, phase_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [7:0]       rem_q, rem_d;
  logic             beat;
  logic             over;

  assign rx.ready = !q_full_i;
  assign beat     = rx.valid && rx.ready;
  assign over     = (pos_q >= PosW'(MAX_DATAGRAM));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cadr_pkg::PH_HEADER;
      pos_q   <= '0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
    end
  end

  always_comb begin
    phase_d       = phase_q;
    pos_d         = pos_q;
    rem_d         = rem_q;
    q_push_o      = 1'b0;
    q_cmd_o.kind  = cadr_pkg::CMD_ECHO;
    q_cmd_o.data  = rx.rx_byte;

    if (beat) begin
      if (over || phase_q == cadr_pkg::PH_DONE) begin
        // dropped byte; the end mark still closes the datagram
        if (rx.end_of_datagram) begin
          if (phase_q != cadr_pkg::PH_DONE) begin
            q_push_o     = 1'b1;
            q_cmd_o.kind = cadr_pkg::CMD_DISCARD;
          end
          phase_d = cadr_pkg::PH_HEADER;
          pos_d   = '0;
          rem_d   = '0;
        end
      end else if (rx.end_of_datagram &&
                   (phase_q != cadr_pkg::PH_TAIL || rem_q != 8'd1)) begin
        // question incomplete
        q_push_o     = 1'b1;
        q_cmd_o.kind = cadr_pkg::CMD_DISCARD;
        phase_d      = cadr_pkg::PH_HEADER;
        pos_d        = '0;
        rem_d        = '0;
      end else begin
        q_push_o = 1'b1;
        pos_d    = pos_q + PosW'(1);
        case (phase_q)
          cadr_pkg::PH_HEADER: begin
            q_cmd_o.data = cadr_pkg::header_byte(pos_q[3:0], rx.rx_byte);
            if (pos_q == PosW'(cadr_pkg::HeaderLen - 1)) begin
              phase_d = cadr_pkg::PH_LABLEN;
            end
          end
          cadr_pkg::PH_LABLEN: begin
            if (rx.rx_byte == 8'd0) begin
              phase_d = cadr_pkg::PH_TAIL;
              rem_d   = 8'(cadr_pkg::TailLen);
            end else begin
              phase_d = cadr_pkg::PH_LABEL;
              rem_d   = rx.rx_byte;
            end
          end
          cadr_pkg::PH_LABEL: begin
            rem_d = rem_q - 8'd1;
            if (rem_q == 8'd1) begin
              phase_d = cadr_pkg::PH_LABLEN;
            end
          end
          cadr_pkg::PH_TAIL: begin
            rem_d = rem_q - 8'd1;
            if (rem_q == 8'd1) begin
              q_cmd_o.kind = cadr_pkg::CMD_ANSWER;
              phase_d      = cadr_pkg::PH_DONE;
              rem_d        = '0;
              if (rx.end_of_datagram) begin
                phase_d = cadr_pkg::PH_HEADER;
                pos_d   = '0;
              end
            end
          end
          default: begin
            q_push_o = 1'b0;
          end
        endcase
      end
    end
  end

endmodule

### rtl/cadr_fifo.sv
// ----------------------------------------------------------------------------
// cadr_fifo: command queue between parser and reply sequencer
// Small flop-based FIFO; full and empty come straight from the fill count.
// ----------------------------------------------------------------------------
module cadr_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cadr_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output cadr_pkg::cmd_t  cmd_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = cadr_pkg::QueuePtrW;
  localparam int unsigned CntW = PtrW + 1;

  cadr_pkg::cmd_t        mem_q [cadr_pkg::QueueDepth];
  logic [PtrW-1:0]       wr_q, wr_d;
  logic [PtrW-1:0]       rd_q, rd_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (cnt_q == CntW'(cadr_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + PtrW'(1) : wr_q;
    rd_d  = do_pop  ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

### rtl/cadr_back.sv
// ----------------------------------------------------------------------------
// cadr_back: reply sequencer
// Pops commands and drives the reply through an output register; an answer
// command appends the 16-byte A record.
// ----------------------------------------------------------------------------
module cadr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [31:0]     answer_ipv4_i,
  input  logic            q_empty_i,
  input  cadr_pkg::cmd_t  q_cmd_i,
  output logic            q_pop_o,
  cadr_tx_if.source       tx
);

  logic        valid_q, valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        eor_q, eor_d;
  logic        disc_q, disc_d;
  logic [4:0]  ans_cnt_q, ans_cnt_d;   // A record bytes still to send
  logic        load;
  logic [4:0]  ans_idx;

  assign tx.valid           = valid_q;
  assign tx.tx_byte         = byte_q;
  assign tx.end_of_response = eor_q;
  assign tx.discard         = disc_q;

  assign load    = !valid_q || tx.ready;
  assign ans_idx = 5'(cadr_pkg::AnswerLen) - ans_cnt_q;

  always_comb begin
    valid_d   = valid_q;
    byte_d    = byte_q;
    eor_d     = eor_q;
    disc_d    = disc_q;
    ans_cnt_d = ans_cnt_q;
    q_pop_o   = 1'b0;

    if (load) begin
      valid_d = 1'b0;
      if (ans_cnt_q != '0) begin
        valid_d   = 1'b1;
        byte_d    = cadr_pkg::answer_byte(ans_idx[3:0], answer_ipv4_i);
        eor_d     = (ans_cnt_q == 5'd1);
        disc_d    = 1'b0;
        ans_cnt_d = ans_cnt_q - 5'd1;
      end else if (!q_empty_i) begin
        q_pop_o = 1'b1;
        valid_d = 1'b1;
        eor_d   = 1'b0;
        case (q_cmd_i.kind)
          cadr_pkg::CMD_DISCARD: begin
            byte_d = 8'h00;
            disc_d = 1'b1;
          end
          cadr_pkg::CMD_ANSWER: begin
            byte_d    = q_cmd_i.data;
            disc_d    = 1'b0;
            ans_cnt_d = 5'(cadr_pkg::AnswerLen);
          end
          default: begin
            byte_d = q_cmd_i.data;
            disc_d = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      ans_cnt_q <= '0;
    end else begin
      valid_q   <= valid_d;
      ans_cnt_q <= ans_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    eor_q  <= eor_d;
    disc_q <= disc_d;
  end

endmodule

### rtl/catch_all_dns_responder_unit.sv
// Path: a query beat passes the parser, the 4-entry command queue and the
// output register on its way to the reply.
// Throughput: one beat per cycle in and out while neither side stalls; the
// last question beat adds the A record, and the queue lets the parser run ahead.
// Reset: rst_ni async low clears parser state, queue and output valid;
// answer address returns to hex C0A80401.
// ----------------------------------------------------------------------------
// catch_all_dns_responder_unit: DNS responder answering every name with one
// address. Rewrites the header, echoes the question and appends an A record.
// ----------------------------------------------------------------------------
module catch_all_dns_responder_unit #(
  parameter int unsigned MAX_DATAGRAM = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cadr_rx_if.sink    rx_i,
  cadr_tx_if.source  tx_o,
  cadr_cfg_if.sink   cfg_i
);

  logic [31:0]    answer_q;
  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_empty;
  cadr_pkg::cmd_t q_wr_cmd;
  cadr_pkg::cmd_t q_rd_cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      answer_q <= cadr_pkg::AnswerIpv4Reset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      answer_q <= cfg_i.answer_ipv4;
    end
  end

  cadr_front #(
    .MAX_DATAGRAM(MAX_DATAGRAM)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx       (rx_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_wr_cmd)
  );

  cadr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_wr_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (q_rd_cmd),
    .empty_o (q_empty)
  );

  cadr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .answer_ipv4_i (answer_q),
    .q_empty_i     (q_empty),
    .q_cmd_i       (q_rd_cmd),
    .q_pop_o       (q_pop),
    .tx            (tx_o)
  );

endmodule

### rtl/cadr_checker.sv
// ----------------------------------------------------------------------------
// cadr_checker: port-level checks for the DNS responder
// Watches the reply channel; bound to the top level.
// ----------------------------------------------------------------------------
module cadr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       tx_valid_i,
  input logic       tx_ready_i,
  input logic [7:0] tx_byte_i,
  input logic       tx_eor_i,
  input logic       tx_discard_i
);

  // stalled reply beat holds
  a_tx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && !tx_ready_i |=> tx_valid_i && $stable(tx_byte_i) &&
      $stable(tx_eor_i) && $stable(tx_discard_i))
    else $error("reply beat changed while stalled");

  // discard beat carries zero and never closes a reply
  a_discard_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && tx_discard_i |-> tx_byte_i == 8'h00 && !tx_eor_i)
    else $error("discard beat with data or end mark");

  // an accepted end-of-reply beat is never a discard beat
  a_eor_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && tx_ready_i && tx_eor_i |-> !tx_discard_i)
    else $error("end of reply marked on a discard beat");

  // nothing pending right out of reset
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !tx_valid_i)
    else $error("reply valid right after reset");

endmodule

bind catch_all_dns_responder_unit cadr_checker u_cadr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .tx_valid_i   (tx_o.valid),
  .tx_ready_i   (tx_o.ready),
  .tx_byte_i    (tx_o.tx_byte),
  .tx_eor_i     (tx_o.end_of_response),
  .tx_discard_i (tx_o.discard)
);

### tb/dns_reply_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dns_reply_checker: reply predictor and scoreboard for the DNS responder
// Watches the query, reply and address channels, predicts every reply beat
// from the accepted query beats and compares them in order.
// ----------------------------------------------------------------------------
module dns_reply_checker #(
  parameter int unsigned MaxDatagram = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cadr_rx_if          rx_i,
  cadr_tx_if          tx_i,
  cadr_cfg_if         cfg_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  localparam logic [7:0] FlagsHi  = 8'h81;
  localparam logic [7:0] FlagsLo  = 8'h80;
  // fixed part of the A record: name pointer, type A, class IN, TTL 0, RDLENGTH 4
  localparam logic [95:0] RecordHead = 96'hC00C_0001_0001_0000_0000_0004;

  typedef struct packed {
    logic [7:0] data;
    logic       eor;
    logic       disc;
  } reply_beat_t;

  reply_beat_t        reply_q[$];
  int unsigned        parse_pos   = 0;
  cadr_pkg::phase_e   parse_phase = cadr_pkg::PH_HEADER;
  logic [7:0]         label_left  = '0;
  logic [31:0]        answer_ip   = cadr_pkg::AnswerIpv4Reset;

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  task automatic push_beat(input logic [7:0] d, input logic eor, input logic disc);
    reply_beat_t rb;
    rb.data = d;
    rb.eor  = eor;
    rb.disc = disc;
    reply_q.push_back(rb);
  endtask

  task automatic restart_parse();
    parse_pos   = 0;
    parse_phase = cadr_pkg::PH_HEADER;
    label_left  = '0;
  endtask

  // expected reply beats for one accepted query beat
  task automatic predict_reply(input logic [7:0] b, input logic last);
    logic [7:0]   v;
    logic         complete;
    logic [127:0] rec;
    complete = 1'b0;
    rec = {RecordHead, answer_ip};

    // past the size limit or past the question: nothing echoed
    if (parse_pos >= MaxDatagram || parse_phase == cadr_pkg::PH_DONE) begin
      if (last) begin
        if (parse_phase != cadr_pkg::PH_DONE) push_beat(8'h00, 1'b0, 1'b1);
        restart_parse();
      end
      return;
    end

    // datagram ends before the question is complete
    if (last && (parse_phase != cadr_pkg::PH_TAIL || label_left != 8'd1)) begin
      push_beat(8'h00, 1'b0, 1'b1);
      restart_parse();
      return;
    end

    case (parse_phase)
      cadr_pkg::PH_HEADER: begin
        v = b;
        case (parse_pos)
          2:               v = FlagsHi;
          3:               v = FlagsLo;
          6:               v = 8'h00;
          7:               v = 8'h01;
          8, 9, 10, 11:    v = 8'h00;
          default:         v = b;
        endcase
        push_beat(v, 1'b0, 1'b0);
        if (parse_pos == cadr_pkg::HeaderLen - 1) parse_phase = cadr_pkg::PH_LABLEN;
      end
      cadr_pkg::PH_LABLEN: begin
        push_beat(b, 1'b0, 1'b0);
        if (b == 8'h00) begin
          parse_phase = cadr_pkg::PH_TAIL;
          label_left  = 8'(cadr_pkg::TailLen);
        end else begin
          parse_phase = cadr_pkg::PH_LABEL;
          label_left  = b;
        end
      end
      cadr_pkg::PH_LABEL: begin
        push_beat(b, 1'b0, 1'b0);
        label_left = label_left - 8'd1;
        if (label_left == 8'd0) parse_phase = cadr_pkg::PH_LABLEN;
      end
      default: begin
        push_beat(b, 1'b0, 1'b0);
        label_left = label_left - 8'd1;
        if (label_left == 8'd0) complete = 1'b1;
      end
    endcase

    parse_pos++;

    if (complete) begin
      for (int i = 0; i < cadr_pkg::AnswerLen; i++)
        push_beat(rec[127 - 8*i -: 8], i == cadr_pkg::AnswerLen - 1, 1'b0);
      parse_phase = cadr_pkg::PH_DONE;
      label_left  = '0;
      if (last) restart_parse();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_beat_t got, want;
    if (!rst_ni) begin
      restart_parse();
      answer_ip = cadr_pkg::AnswerIpv4Reset;
      reply_q.delete();
    end else begin
      if (tx_i.valid && tx_i.ready) begin
        got = {tx_i.tx_byte, tx_i.end_of_response, tx_i.discard};
        if (reply_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected reply beat, expected none got %02h/%0b/%0b",
                   $time, got.data, got.eor, got.disc);
        end else begin
          want = reply_q.pop_front();
          if (got !== want) begin
            errors_o++;
            $display("%0t: reply mismatch, expected %02h/%0b/%0b got %02h/%0b/%0b",
                     $time, want.data, want.eor, want.disc,
                     got.data, got.eor, got.disc);
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) answer_ip = cfg_i.answer_ipv4;
      if (rx_i.valid && rx_i.ready) predict_reply(rx_i.rx_byte, rx_i.end_of_datagram);
    end
    pending_o = reply_q.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the catch-all DNS responder
// Sends directed and random query datagrams (well formed, truncated, short,
// noisy, oversize) under varying back-pressure and answer addresses.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MaxDatagram = 256;
  localparam int unsigned PhaseBeats  = 30;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned StallCycles = 300;

  logic        clk_i;
  logic        rst_ni;
  int unsigned errors;
  int unsigned pending;

  int unsigned rx_idle_pct = 0;
  int unsigned tx_idle_pct = 0;
  logic        stall_req   = 1'b0;
  int unsigned n_beats     = 0;
  int unsigned n_queries   = 0;
  int unsigned n_ip_writes = 0;
  logic [7:0]  query_q[$];

  cadr_rx_if  rx ();
  cadr_tx_if  tx ();
  cadr_cfg_if cfg ();

  catch_all_dns_responder_unit #(
    .MAX_DATAGRAM(MaxDatagram)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx),
    .tx_o  (tx),
    .cfg_i (cfg)
  );

  dns_reply_checker #(
    .MaxDatagram(MaxDatagram)
  ) i_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx_i     (rx),
    .tx_i     (tx),
    .cfg_i    (cfg),
    .errors_o (errors),
    .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("Some tests failed");
    $finish;
  end

  // reply side: random stalls, plus one long hold-off on request
  initial begin : reply_sink
    int unsigned held;
    tx.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        tx.ready <= 1'b0;
        for (held = 0; held < StallCycles; held++) @(negedge clk_i);
        stall_req = 1'b0;
      end
      tx.ready <= ($urandom_range(99) >= tx_idle_pct);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    while (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
      rx.valid <= 1'b0;
      @(negedge clk_i);
    end
    rx.valid           <= 1'b1;
    rx.rx_byte         <= b;
    rx.end_of_datagram <= last;
    do @(posedge clk_i); while (!rx.ready);
    @(negedge clk_i);
    n_beats++;
  endtask

  task automatic send_query();
    for (int i = 0; i < query_q.size(); i++)
      send_beat(query_q[i], i == query_q.size() - 1);
    n_queries++;
  endtask

  task automatic wait_idle();
    rx.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_answer_ip(input logic [31:0] ip);
    wait_idle();
    cfg.valid       <= 1'b1;
    cfg.answer_ipv4 <= ip;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
    n_ip_writes++;
  endtask

  // random query: mostly well formed, some truncated, short or noisy
  task automatic build_query();
    int unsigned kind, n_labels, len, cut;
    query_q.delete();
    kind = $urandom_range(99);
    for (int i = 0; i < cadr_pkg::HeaderLen; i++)
      query_q.push_back(8'($urandom_range(255)));
    n_labels = $urandom_range(3);
    for (int l = 0; l < n_labels; l++) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(63, 9) : $urandom_range(6, 1);
      query_q.push_back(8'(len));
      for (int j = 0; j < len; j++) query_q.push_back(8'($urandom_range(255)));
    end
    query_q.push_back(8'h00);
    for (int i = 0; i < cadr_pkg::TailLen; i++) query_q.push_back(8'($urandom_range(255)));
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(4, 1)) query_q.push_back(8'($urandom_range(255)));

    if (kind >= 65 && kind < 80) begin
      cut = $urandom_range(query_q.size() - 1, 1);
      while (query_q.size() > cut) void'(query_q.pop_back());
    end else if (kind >= 80 && kind < 90) begin
      cut = $urandom_range(cadr_pkg::HeaderLen - 1, 1);
      while (query_q.size() > cut) void'(query_q.pop_back());
    end else if (kind >= 90) begin
      // random bytes after the header: label counts land anywhere
      len = $urandom_range(40, cadr_pkg::HeaderLen + 1);
      while (query_q.size() > cadr_pkg::HeaderLen) void'(query_q.pop_back());
      while (query_q.size() < len) query_q.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic random_phase();
    int unsigned start;
    start = n_beats;
    while (n_beats - start < PhaseBeats) begin
      build_query();
      send_query();
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    rx.valid           = 1'b0;
    rx.rx_byte         = '0;
    rx.end_of_datagram = 1'b0;
    cfg.valid          = 1'b0;
    cfg.answer_ipv4    = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: one-byte datagram, then a one-label query with extreme
    // header and tail bytes ending on the completing beat, then a short one
    query_q = '{8'h00};
    send_query();
    query_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h80, 8'h00,
                8'hFF, 8'hFF, 8'h00, 8'h00};
    send_query();
    query_q = '{8'hFF, 8'h00, 8'hFF};
    send_query();

    write_answer_ip(32'h0000_0000);
    rx_idle_pct = 8;
    tx_idle_pct = 79;
    random_phase();

    write_answer_ip(32'hFFFF_FFFF);
    rx_idle_pct = 79;
    tx_idle_pct = 8;
    random_phase();

    write_answer_ip($urandom);
    rx_idle_pct = 0;
    tx_idle_pct = 0;
    // long reply stall while queries keep coming
    stall_req = 1'b1;
    random_phase();
    // oversize datagram: a 255-byte label runs past the size limit
    query_q.delete();
    for (int i = 0; i < cadr_pkg::HeaderLen; i++)
      query_q.push_back(8'($urandom_range(255)));
    query_q.push_back(8'hFF);
    repeat (255) query_q.push_back(8'($urandom_range(255)));
    send_query();
    random_phase();

    wait_idle();
    $display("Sent %0d query beats in %0d datagrams, %0d answer address writes,",
             n_beats, n_queries, n_ip_writes);
    $display("with truncated, short, noisy and oversize datagrams and a long stall.");
    if (pending != 0) $display("%0d reply beats never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
